// ===== sv/sss_pkg.sv =====
package sss_pkg;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_BLOCK = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] ADDR_COUNT = 2'd0;

    localparam logic [63:0] MIX_MULT = 64'd2685821657736338717;

    localparam int IN_BITS  = 200;
    localparam int IN_BYTES = 25;
    localparam int OUT_BITS = 40;

    typedef struct packed {
        logic [31:0] scheduled_id;
        logic        reshuffled;
        logic        status;
    } result_t;

endpackage

// ===== sv/sss_divider.sv =====
module sss_divider #(
    parameter int NW = 64,
    parameter int DW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          done,
    output logic [DW-1:0] remainder
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW+1:0] trial;
    logic [DW+1:0] shifted;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign trial   = shifted - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], 1'b0};
            if (!trial[DW+1])
                rem_reg <= trial[DW:0];
            else
                rem_reg <= shifted[DW:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[DW-1:0];

endmodule

// ===== sv/sss_mixer.sv =====
module sss_mixer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] seconds,
    input  logic [63:0] pos_mult,
    output logic        done,
    output logic [63:0] mix
);

    typedef enum logic [6:0] {
        M_IDLE = 7'b0000001,
        M_XOR  = 7'b0000010,
        M_LO   = 7'b0000100,
        M_HI1  = 7'b0001000,
        M_HI2  = 7'b0010000,
        M_SUM  = 7'b0100000,
        M_DONE = 7'b1000000
    } mstate_t;

    mstate_t     state_reg;
    logic [63:0] k_reg;
    logic [63:0] p_lo_reg;
    logic [31:0] p_h1_reg;
    logic [31:0] p_h2_reg;
    logic [63:0] mix_reg;
    logic [63:0] k1;
    logic [63:0] k2;
    logic [63:0] k3;

    assign k1 = k_reg ^ (k_reg >> 12);
    assign k2 = k1 ^ (k1 << 25);
    assign k3 = k2 ^ (k2 >> 27);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= M_IDLE;
        else
        begin
            unique case (state_reg)
                M_IDLE: if (start) state_reg <= M_XOR;
                M_XOR:  state_reg <= M_LO;
                M_LO:   state_reg <= M_HI1;
                M_HI1:  state_reg <= M_HI2;
                M_HI2:  state_reg <= M_SUM;
                M_SUM:  state_reg <= M_DONE;
                M_DONE: state_reg <= M_IDLE;
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE: if (start) k_reg <= {seconds, 32'd0} + pos_mult;
            M_XOR:  k_reg <= k3;
            M_LO:   p_lo_reg <= k_reg[31:0] * sss_pkg::MIX_MULT[31:0];
            M_HI1:  p_h1_reg <= 32'(k_reg[31:0] * sss_pkg::MIX_MULT[63:32]);
            M_HI2:  p_h2_reg <= 32'(k_reg[63:32] * sss_pkg::MIX_MULT[31:0]);
            M_SUM:  mix_reg <= p_lo_reg + {p_h1_reg + p_h2_reg, 32'd0};
            default: ;
        endcase
    end

    assign done = (state_reg == M_DONE);
    assign mix  = mix_reg;

endmodule

// ===== sv/shuffled_slot_schedule.sv =====
// Slot schedule: loads write the active list, a new-block transaction whose block
// number is a multiple of producer_count (capped at MAX_PRODUCERS) copies the list
// and runs a Fisher-Yates shuffle, and queries read the shuffled entry at
// (absolute_slot + slot_offset) mod length. One transaction is processed at a
// time. A query or block item uses a 64-step bit-serial modulo; a reshuffle first
// copies the active list into the shuffled memory, then per position runs a staged
// mix multiply, a bit-serial modulo and a read-swap-write (S_RDI, S_RDJ, S_WRI) on
// the shuffled memory. After reset the shuffled memory is swept clear before the
// first transaction is accepted.
module shuffled_slot_schedule #(
    parameter int MAX_PRODUCERS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_type[1:0], entry_index[7:2], producer_id[39:8], block_number[71:40],
    // block_time_sec[103:72], absolute_slot[167:104], slot_offset[199:168]
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // scheduled_id[31:0], reshuffled[32], status[33]
    output logic [39:0]  m_tdata
);

    localparam int AW = (MAX_PRODUCERS > 1) ? $clog2(MAX_PRODUCERS) : 1;
    localparam int LW = $clog2(MAX_PRODUCERS + 1);
    localparam int DW = (LW > 7) ? LW : 7;

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_BDIV  = 13'b0000000000100,
        S_COPYR = 13'b0000000001000,
        S_COPYW = 13'b0000000010000,
        S_MIX   = 13'b0000000100000,
        S_MOD   = 13'b0000001000000,
        S_RDI   = 13'b0000010000000,
        S_RDJ   = 13'b0000100000000,
        S_WRI   = 13'b0001000000000,
        S_QDIV  = 13'b0010000000000,
        S_QRD   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    state_t          state_reg;
    logic [6:0]      count_reg;
    logic [LW-1:0]   len_reg;
    logic [LW-1:0]   cur_len_reg;
    logic [LW-1:0]   i_reg;
    logic [AW-1:0]   j_reg;
    logic [31:0]     ti_reg;
    logic [31:0]     seconds_reg;
    logic [63:0]     pmul_reg;
    logic            out_valid_reg;
    sss_pkg::result_t res_reg;

    logic [31:0] active_mem [MAX_PRODUCERS];
    logic [31:0] shuf_mem [MAX_PRODUCERS];
    logic [31:0] act_rd_reg;
    logic [31:0] sh_rd_reg;

    logic [1:0]  req_type;
    logic [5:0]  entry_index;
    logic [31:0] producer_id;
    logic [31:0] block_number;
    logic [63:0] absolute_slot;
    logic [31:0] slot_offset;

    assign req_type      = s_tdata[1:0];
    assign entry_index   = s_tdata[7:2];
    assign producer_id   = s_tdata[39:8];
    assign block_number  = s_tdata[71:40];
    assign absolute_slot = s_tdata[167:104];
    assign slot_offset   = s_tdata[199:168];

    logic [LW-1:0] eff_count;
    always_comb
    begin
        if ({25'd0, count_reg} > 32'(MAX_PRODUCERS))
            eff_count = LW'(MAX_PRODUCERS);
        else
            eff_count = LW'(count_reg);
    end

    logic          accept;
    logic          div_start;
    logic [63:0]   div_numer;
    logic [DW-1:0] div_denom;
    logic          div_done;
    logic [DW-1:0] div_rem;
    logic          mix_start;
    logic          mix_done;
    logic [63:0]   mix;

    assign accept = s_tvalid && s_tready;
    assign pready = 1'b1;
    assign prdata = {25'd0, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 7'd1;
        else if (psel && penable && pwrite && paddr == sss_pkg::ADDR_COUNT)
            count_reg <= pwdata[6:0];
    end

    sss_divider #(.NW(64), .DW(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numer     (div_numer),
        .denom     (div_denom),
        .done      (div_done),
        .remainder (div_rem)
    );

    sss_mixer u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mix_start),
        .seconds  (seconds_reg),
        .pos_mult (pmul_reg),
        .done     (mix_done),
        .mix      (mix)
    );

    always_comb
    begin
        div_start = 1'b0;
        div_numer = 64'd0;
        div_denom = DW'(1);
        if (state_reg == S_IDLE && accept && req_type == sss_pkg::REQ_BLOCK
            && eff_count != '0)
        begin
            div_start = 1'b1;
            div_numer = {32'd0, block_number};
            div_denom = DW'(eff_count);
        end
        else if (state_reg == S_IDLE && accept && req_type == sss_pkg::REQ_QUERY
                 && cur_len_reg != '0)
        begin
            div_start = 1'b1;
            div_numer = absolute_slot + {32'd0, slot_offset};
            div_denom = DW'(cur_len_reg);
        end
        else if (state_reg == S_MIX && mix_done)
        begin
            div_start = 1'b1;
            div_numer = mix;
            div_denom = DW'(len_reg - i_reg);
        end
    end

    assign mix_start = (state_reg == S_COPYW && i_reg == len_reg - 1'b1)
                    || (state_reg == S_WRI && i_reg != len_reg - 1'b1);
    assign s_tready  = (state_reg == S_IDLE) && !out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept && req_type == sss_pkg::REQ_LOAD
            && 32'(entry_index) < 32'(MAX_PRODUCERS))
            active_mem[AW'(entry_index)] <= producer_id;
        act_rd_reg <= active_mem[AW'(i_reg)];
    end

    logic          sh_we;
    logic [AW-1:0] sh_waddr;
    logic [31:0]   sh_wdata;
    logic [AW-1:0] sh_raddr;

    always_comb
    begin
        sh_we    = 1'b0;
        sh_waddr = AW'(i_reg);
        sh_wdata = act_rd_reg;
        sh_raddr = AW'(i_reg);
        unique case (state_reg)
            S_CLEAR: begin sh_we = 1'b1; sh_wdata = 32'd0; end
            S_COPYW: sh_we = 1'b1;
            S_RDJ:   begin sh_we = 1'b1; sh_wdata = sh_rd_reg; end
            S_WRI:   begin sh_we = 1'b1; sh_waddr = j_reg; sh_wdata = ti_reg; end
            S_MOD:   sh_raddr = AW'(i_reg);
            S_RDI:   sh_raddr = j_reg;
            S_QDIV:  sh_raddr = AW'(div_rem);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sh_we)
            shuf_mem[sh_waddr] <= sh_wdata;
        sh_rd_reg <= shuf_mem[sh_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            i_reg         <= '0;
            cur_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == LW'(MAX_PRODUCERS - 1))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_reg <= '{scheduled_id: 32'd0, reshuffled: 1'b0,
                                     status: (req_type == sss_pkg::REQ_QUERY)
                                             && (cur_len_reg == '0)};
                        if (req_type == sss_pkg::REQ_BLOCK && eff_count != '0)
                        begin
                            len_reg   <= eff_count;
                            state_reg <= S_BDIV;
                        end
                        else if (req_type == sss_pkg::REQ_QUERY)
                        begin
                            if (cur_len_reg == '0)
                                state_reg <= S_OUT;
                            else
                                state_reg <= S_QDIV;
                        end
                        else
                            state_reg <= S_OUT;
                        seconds_reg <= s_tdata[103:72];
                    end
                end
                S_BDIV:
                begin
                    if (div_done)
                    begin
                        if (div_rem == '0)
                        begin
                            i_reg     <= '0;
                            pmul_reg  <= 64'd0;
                            state_reg <= S_COPYR;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_COPYR: state_reg <= S_COPYW;
                S_COPYW:
                begin
                    if (i_reg == len_reg - 1'b1)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_MIX;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_COPYR;
                    end
                end
                S_MIX: if (mix_done) state_reg <= S_MOD;
                S_MOD:
                begin
                    if (div_done)
                    begin
                        j_reg     <= AW'(i_reg + LW'(div_rem));
                        state_reg <= S_RDI;
                    end
                end
                S_RDI:
                begin
                    ti_reg    <= sh_rd_reg;
                    pmul_reg  <= pmul_reg + sss_pkg::MIX_MULT;
                    state_reg <= S_RDJ;
                end
                S_RDJ: state_reg <= S_WRI;
                S_WRI:
                begin
                    if (i_reg == len_reg - 1'b1)
                    begin
                        cur_len_reg        <= len_reg;
                        res_reg.reshuffled <= 1'b1;
                        state_reg          <= S_OUT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_MIX;
                    end
                end
                S_QDIV: if (div_done) state_reg <= S_QRD;
                S_QRD:
                begin
                    res_reg.scheduled_id <= sh_rd_reg;
                    state_reg            <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // S_RDJ writes shuf[j] (read in S_RDI) to i; S_WRI writes old shuf[i] (ti) to j.
    // Read order: S_MOD reads i, S_RDI reads j (data arrives in S_RDJ as sh_rd_reg).
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, res_reg.status, res_reg.reshuffled, res_reg.scheduled_id};

`ifndef SYNTH
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while result pending");
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_len_reg) <= 32'(MAX_PRODUCERS))
        else $error("schedule length out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
`endif

endmodule
